// ----- design/ibhpq_pkg.sv -----
package ibhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int KEY_W    = 32;

	localparam logic [2:0] CMD_INSERT   = 3'd0;
	localparam logic [2:0] CMD_DEL_TOP  = 3'd1;
	localparam logic [2:0] CMD_REMOVE   = 3'd2;
	localparam logic [2:0] CMD_CHANGE   = 3'd3;
	localparam logic [2:0] CMD_DECREASE = 3'd4;
	localparam logic [2:0] CMD_INCREASE = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_PRESENT   = 3'd2;
	localparam logic [2:0] ST_ABSENT    = 3'd3;
	localparam logic [2:0] ST_NOCHANGE  = 3'd4;

	typedef struct packed {
		logic [2:0]       command;
		logic [IDX_W-1:0] slot_index;
		logic [KEY_W-1:0] key_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] removed_index;
		logic [KEY_W-1:0] removed_key;
		logic [CNT_W-1:0] entry_count;
		logic             top_valid;
		logic [IDX_W-1:0] top_index;
		logic [KEY_W-1:0] top_key;
	} rsp_t;

	// one heap entry carries its slot and that slot's key
	typedef struct packed {
		logic [IDX_W-1:0] slot;
		logic [KEY_W-1:0] key;
	} heap_ent_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_CUR,
		S_FUP,
		S_FUP_CMP,
		S_SNK_LD,
		S_SNK_LDW,
		S_SNK,
		S_SNK_CMP,
		S_FIN,
		S_OUT
	} state_t;

endpackage

// ----- design/indexed_binary_heap_priority_queue.sv -----
// Each command goes through the lookup, which may settle it; a read of the entry's position when
// needed; then the swim or sink loop, one heap level per pass, and a closing step before the response.
// Throughput: one command at a time; the next command is taken the cycle after the response
// is registered, and an unaccepted earlier response holds the queue.
// Reset clears the entry count, the presence bits, the order mode and the response valid;
// heap memory contents stay undefined and are never used beyond the entry count.
module indexed_binary_heap_priority_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  ibhpq_pkg::cmd_t    cmd,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output ibhpq_pkg::rsp_t    rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	localparam int IW = ibhpq_pkg::IDX_W;
	localparam int CW = ibhpq_pkg::CNT_W;

	function automatic logic worse(input logic mode, input logic [ibhpq_pkg::KEY_W-1:0] a,
			input logic [ibhpq_pkg::KEY_W-1:0] b);
		return mode ? (a < b) : (a > b);
	endfunction

	ibhpq_pkg::state_t state_q, state_d;

	// memories
	ibhpq_pkg::heap_ent_t heap_mem [ibhpq_pkg::CAPACITY];
	logic [IW-1:0]        pos_mem  [ibhpq_pkg::CAPACITY];

	ibhpq_pkg::heap_ent_t rd_a_q, rd_b_q;
	logic [IW-1:0]        pos_rd_q;
	logic [IW-1:0]        addr_a, addr_b;
	logic                 heap_we, pos_we;
	logic [IW-1:0]        heap_wa, pos_wa, pos_wd;
	ibhpq_pkg::heap_ent_t heap_wd;

	// control and payload registers
	logic                         order_q;
	logic [CW-1:0]                cnt_q, cnt_d;
	logic [ibhpq_pkg::CAPACITY-1:0] valid_q, valid_d;
	ibhpq_pkg::cmd_t              cmd_q, cmd_d;
	ibhpq_pkg::heap_ent_t         m_q, m_d;
	logic [IW-1:0]                k_q, k_d, k0_q, k0_d, pos_q, pos_d;
	logic                         sink_after_q, sink_after_d, reload_q, reload_d;
	logic [2:0]                   status_q, status_d;
	logic [IW-1:0]                rem_idx_q, rem_idx_d;
	logic [ibhpq_pkg::KEY_W-1:0]  rem_key_q, rem_key_d;
	logic                         rsp_valid_q, rsp_valid_d;
	ibhpq_pkg::rsp_t              rsp_q, rsp_d;

	// derived values
	logic [CW-1:0]        c_w, c1_w;
	logic [IW-1:0]        par;
	logic                 present, fup_move, pick_b, snk_move, out_free, has_child;
	ibhpq_pkg::heap_ent_t child;
	logic [CW-1:0]        cidx;
	ibhpq_pkg::heap_ent_t newent;

	assign c_w      = {k_q, 1'b1};
	assign c1_w     = c_w + CW'(1);
	assign par      = (k_q - IW'(1)) >> 1;
	assign present  = valid_q[cmd_q.slot_index];
	assign fup_move = worse(order_q, rd_a_q.key, m_q.key);
	assign pick_b   = (c1_w < cnt_q) && worse(order_q, rd_a_q.key, rd_b_q.key);
	assign child    = pick_b ? rd_b_q : rd_a_q;
	assign cidx     = pick_b ? c1_w : c_w;
	assign snk_move = worse(order_q, m_q.key, child.key);
	assign has_child = c_w < cnt_q;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign newent   = '{slot: cmd_q.slot_index, key: cmd_q.key_value};

	assign cmd_ready = (state_q == ibhpq_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ibhpq_pkg::S_IDLE: begin
				if (cmd_valid) state_d = ibhpq_pkg::S_LOOK;
			end
			ibhpq_pkg::S_LOOK: begin
				case (cmd_q.command)
					ibhpq_pkg::CMD_INSERT: begin
						if (present || cnt_q == CW'(ibhpq_pkg::CAPACITY))
							state_d = ibhpq_pkg::S_FIN;
						else
							state_d = ibhpq_pkg::S_FUP;
					end
					ibhpq_pkg::CMD_DEL_TOP: begin
						if (cnt_q <= CW'(1)) state_d = ibhpq_pkg::S_FIN;
						else state_d = ibhpq_pkg::S_SNK;
					end
					ibhpq_pkg::CMD_REMOVE, ibhpq_pkg::CMD_CHANGE,
					ibhpq_pkg::CMD_DECREASE, ibhpq_pkg::CMD_INCREASE: begin
						state_d = present ? ibhpq_pkg::S_CUR : ibhpq_pkg::S_FIN;
					end
					default: state_d = ibhpq_pkg::S_FIN;
				endcase
			end
			ibhpq_pkg::S_CUR: begin
				case (cmd_q.command)
					ibhpq_pkg::CMD_REMOVE: begin
						if (CW'(pos_q) == cnt_q - CW'(1)) state_d = ibhpq_pkg::S_FIN;
						else state_d = ibhpq_pkg::S_FUP;
					end
					ibhpq_pkg::CMD_DECREASE: begin
						if (worse(order_q, cmd_q.key_value, rd_a_q.key))
							state_d = ibhpq_pkg::S_FIN;
						else
							state_d = ibhpq_pkg::S_FUP;
					end
					ibhpq_pkg::CMD_INCREASE: begin
						if (worse(order_q, rd_a_q.key, cmd_q.key_value))
							state_d = ibhpq_pkg::S_FIN;
						else
							state_d = ibhpq_pkg::S_SNK;
					end
					default: state_d = ibhpq_pkg::S_FUP;
				endcase
			end
			ibhpq_pkg::S_FUP, ibhpq_pkg::S_FUP_CMP: begin
				if (state_q == ibhpq_pkg::S_FUP && k_q != '0)
					state_d = ibhpq_pkg::S_FUP_CMP;
				else if (state_q == ibhpq_pkg::S_FUP_CMP && fup_move)
					state_d = ibhpq_pkg::S_FUP;
				else if (!sink_after_q)
					state_d = ibhpq_pkg::S_FIN;
				else if (reload_q)
					state_d = ibhpq_pkg::S_SNK_LD;
				else
					state_d = ibhpq_pkg::S_SNK;
			end
			ibhpq_pkg::S_SNK_LD:  state_d = ibhpq_pkg::S_SNK_LDW;
			ibhpq_pkg::S_SNK_LDW: state_d = ibhpq_pkg::S_SNK;
			ibhpq_pkg::S_SNK: begin
				state_d = has_child ? ibhpq_pkg::S_SNK_CMP : ibhpq_pkg::S_FIN;
			end
			ibhpq_pkg::S_SNK_CMP: begin
				state_d = snk_move ? ibhpq_pkg::S_SNK : ibhpq_pkg::S_FIN;
			end
			ibhpq_pkg::S_FIN: state_d = ibhpq_pkg::S_OUT;
			ibhpq_pkg::S_OUT: begin
				if (out_free) state_d = ibhpq_pkg::S_IDLE;
			end
			default: state_d = ibhpq_pkg::S_IDLE;
		endcase
	end

	// datapath controls and register updates
	always_comb begin
		addr_a       = '0;
		addr_b       = '0;
		heap_we      = 1'b0;
		heap_wa      = k_q;
		heap_wd      = m_q;
		pos_we       = 1'b0;
		pos_wa       = m_q.slot;
		pos_wd       = k_q;
		cnt_d        = cnt_q;
		valid_d      = valid_q;
		cmd_d        = cmd_q;
		m_d          = m_q;
		k_d          = k_q;
		k0_d         = k0_q;
		pos_d        = pos_q;
		sink_after_d = sink_after_q;
		reload_d     = reload_q;
		status_d     = status_q;
		rem_idx_d    = rem_idx_q;
		rem_key_d    = rem_key_q;
		rsp_valid_d  = rsp_valid_q && !rsp_ready;
		rsp_d        = rsp_q;
		case (state_q)
			ibhpq_pkg::S_IDLE: begin
				// fetch root and last entry while the slot's position is looked up
				addr_a    = '0;
				addr_b    = IW'(cnt_q - CW'(1));
				cmd_d     = cmd;
				status_d  = ibhpq_pkg::ST_OK;
				rem_idx_d = '0;
				rem_key_d = '0;
			end
			ibhpq_pkg::S_LOOK: begin
				addr_a = pos_rd_q;
				pos_d  = pos_rd_q;
				m_d    = rd_b_q;
				case (cmd_q.command)
					ibhpq_pkg::CMD_INSERT: begin
						if (present) begin
							status_d = ibhpq_pkg::ST_PRESENT;
						end else if (cnt_q == CW'(ibhpq_pkg::CAPACITY)) begin
							status_d = ibhpq_pkg::ST_NOCHANGE;
						end else begin
							m_d          = newent;
							k_d          = IW'(cnt_q);
							cnt_d        = cnt_q + CW'(1);
							valid_d[cmd_q.slot_index] = 1'b1;
							sink_after_d = 1'b0;
							reload_d     = 1'b0;
						end
					end
					ibhpq_pkg::CMD_DEL_TOP: begin
						if (cnt_q == '0) begin
							status_d = ibhpq_pkg::ST_EMPTY;
						end else begin
							rem_idx_d = rd_a_q.slot;
							rem_key_d = rd_a_q.key;
							valid_d[rd_a_q.slot] = 1'b0;
							cnt_d     = cnt_q - CW'(1);
							k_d       = '0;
						end
					end
					ibhpq_pkg::CMD_REMOVE, ibhpq_pkg::CMD_CHANGE,
					ibhpq_pkg::CMD_DECREASE, ibhpq_pkg::CMD_INCREASE: begin
						if (!present) status_d = ibhpq_pkg::ST_ABSENT;
					end
					default: status_d = ibhpq_pkg::ST_NOCHANGE;
				endcase
			end
			ibhpq_pkg::S_CUR: begin
				k_d          = pos_q;
				k0_d         = pos_q;
				sink_after_d = 1'b0;
				reload_d     = 1'b0;
				case (cmd_q.command)
					ibhpq_pkg::CMD_REMOVE: begin
						// last entry fills the hole, then swim and sink from there
						valid_d[cmd_q.slot_index] = 1'b0;
						cnt_d        = cnt_q - CW'(1);
						sink_after_d = 1'b1;
						reload_d     = 1'b1;
					end
					ibhpq_pkg::CMD_CHANGE: begin
						m_d          = newent;
						sink_after_d = 1'b1;
					end
					ibhpq_pkg::CMD_DECREASE: begin
						m_d = newent;
						if (worse(order_q, cmd_q.key_value, rd_a_q.key))
							status_d = ibhpq_pkg::ST_NOCHANGE;
					end
					default: begin
						m_d = newent;
						if (worse(order_q, rd_a_q.key, cmd_q.key_value))
							status_d = ibhpq_pkg::ST_NOCHANGE;
					end
				endcase
			end
			ibhpq_pkg::S_FUP: begin
				addr_a = par;
				// root reached: drop the moving entry here
				if (k_q == '0) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
					if (reload_q) k_d = k0_q;
				end
			end
			ibhpq_pkg::S_FUP_CMP: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (fup_move) begin
					// parent moves down into the hole
					heap_wd = rd_a_q;
					pos_wa  = rd_a_q.slot;
					k_d     = par;
				end else if (reload_q) begin
					k_d = k0_q;
				end
			end
			ibhpq_pkg::S_SNK_LD: begin
				addr_a = k_q;
			end
			ibhpq_pkg::S_SNK_LDW: begin
				m_d = rd_a_q;
			end
			ibhpq_pkg::S_SNK: begin
				addr_a = c_w[IW-1:0];
				addr_b = c1_w[IW-1:0];
				if (!has_child) begin
					heap_we = 1'b1;
					pos_we  = 1'b1;
				end
			end
			ibhpq_pkg::S_SNK_CMP: begin
				heap_we = 1'b1;
				pos_we  = 1'b1;
				if (snk_move) begin
					// better child moves up into the hole
					heap_wd = child;
					pos_wa  = child.slot;
					k_d     = cidx[IW-1:0];
				end
			end
			ibhpq_pkg::S_FIN: begin
				addr_a = '0;
			end
			ibhpq_pkg::S_OUT: begin
				if (out_free) begin
					rsp_valid_d         = 1'b1;
					rsp_d.status        = status_q;
					rsp_d.removed_index = rem_idx_q;
					rsp_d.removed_key   = rem_key_q;
					rsp_d.entry_count   = cnt_q;
					rsp_d.top_valid     = (cnt_q != '0);
					rsp_d.top_index     = (cnt_q != '0) ? rd_a_q.slot : '0;
					rsp_d.top_key       = (cnt_q != '0) ? rd_a_q.key : '0;
				end
			end
			default: begin
			end
		endcase
		heap_wa = k_q;
		pos_wd  = k_q;
	end

	// heap memory: two registered read ports, one write port
	always_ff @(posedge clk) begin
		if (heap_we) heap_mem[heap_wa] <= heap_wd;
		rd_a_q <= heap_mem[addr_a];
		rd_b_q <= heap_mem[addr_b];
	end

	// position map memory
	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		pos_rd_q <= pos_mem[cmd.slot_index];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ibhpq_pkg::S_IDLE;
			cnt_q       <= '0;
			valid_q     <= '0;
			order_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			valid_q     <= valid_d;
			rsp_valid_q <= rsp_valid_d;
			if (cfg_valid) order_q <= cfg_data;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		m_q          <= m_d;
		k_q          <= k_d;
		k0_q         <= k0_d;
		pos_q        <= pos_d;
		sink_after_q <= sink_after_d;
		reload_q     <= reload_d;
		status_q     <= status_d;
		rem_idx_q    <= rem_idx_d;
		rem_key_q    <= rem_key_d;
		rsp_q        <= rsp_d;
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(ibhpq_pkg::CAPACITY))
		else $error("entry count beyond capacity");
	a_valid_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ibhpq_pkg::S_IDLE |-> CW'($countones(valid_q)) == cnt_q)
		else $error("presence bits disagree with entry count");
	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.top_valid == (rsp_q.entry_count != '0))
		else $error("top valid disagrees with entry count");
`endif

endmodule

// ----- tb/heap_result_checker.sv -----
`timescale 1ns / 100ps

module heap_result_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic             cmd_ready,
	input  ibhpq_pkg::cmd_t  cmd,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  ibhpq_pkg::rsp_t  rsp,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic             cfg_data,
	output int               errors,
	output int               pending
);

	localparam int KW  = ibhpq_pkg::KEY_W;
	localparam int IW  = ibhpq_pkg::IDX_W;
	localparam int CW  = ibhpq_pkg::CNT_W;
	localparam int CAP = ibhpq_pkg::CAPACITY;

	// shadow copy of the queue
	logic             largest_on_top;
	logic [IW-1:0]    heap_slot [CAP];
	int               heap_pos  [CAP];
	logic [KW-1:0]    slot_key  [CAP];
	int               entries;
	ibhpq_pkg::rsp_t  expected_rsp [$];

	function automatic bit key_worse(logic [KW-1:0] a, logic [KW-1:0] b);
		return largest_on_top ? (a < b) : (a > b);
	endfunction

	function automatic bit pos_worse(int p, int q);
		return key_worse(slot_key[heap_slot[p]], slot_key[heap_slot[q]]);
	endfunction

	function automatic void swap_pos(int p, int q);
		logic [IW-1:0] t;
		t = heap_slot[p];
		heap_slot[p] = heap_slot[q];
		heap_slot[q] = t;
		heap_pos[heap_slot[p]] = p;
		heap_pos[heap_slot[q]] = q;
	endfunction

	function automatic void swim(int k);
		int p;
		while (k > 0) begin
			p = (k - 1) / 2;
			if (!pos_worse(p, k))
				break;
			swap_pos(p, k);
			k = p;
		end
	endfunction

	function automatic void sink(int k);
		int c;
		c = 2 * k + 1;
		while (c < entries) begin
			if (c + 1 < entries && pos_worse(c, c + 1))
				c++;
			if (!pos_worse(k, c))
				break;
			swap_pos(k, c);
			k = c;
			c = 2 * k + 1;
		end
	endfunction

	function automatic bit slot_present(logic [IW-1:0] s);
		return heap_pos[s] < entries;
	endfunction

	// apply one command to the shadow heap and form its response
	function automatic ibhpq_pkg::rsp_t apply_command(ibhpq_pkg::cmd_t c);
		ibhpq_pkg::rsp_t r;
		int k;
		logic [IW-1:0] s;
		r = '0;
		r.status = ibhpq_pkg::ST_OK;
		s = c.slot_index;
		case (c.command)
			ibhpq_pkg::CMD_INSERT: begin
				if (slot_present(s)) begin
					r.status = ibhpq_pkg::ST_PRESENT;
				end else if (entries >= CAP) begin
					r.status = ibhpq_pkg::ST_NOCHANGE;
				end else begin
					k = entries;
					heap_slot[k] = s;
					heap_pos[s] = k;
					slot_key[s] = c.key_value;
					entries++;
					swim(k);
				end
			end
			ibhpq_pkg::CMD_DEL_TOP: begin
				if (entries == 0) begin
					r.status = ibhpq_pkg::ST_EMPTY;
				end else begin
					s = heap_slot[0];
					r.removed_index = s;
					r.removed_key = slot_key[s];
					swap_pos(0, entries - 1);
					entries--;
					sink(0);
					heap_pos[s] = CAP;
					slot_key[s] = '0;
				end
			end
			ibhpq_pkg::CMD_REMOVE, ibhpq_pkg::CMD_CHANGE,
			ibhpq_pkg::CMD_DECREASE, ibhpq_pkg::CMD_INCREASE: begin
				if (!slot_present(s)) begin
					r.status = ibhpq_pkg::ST_ABSENT;
				end else if (c.command == ibhpq_pkg::CMD_REMOVE) begin
					k = heap_pos[s];
					swap_pos(k, entries - 1);
					entries--;
					// skip reheap when the hole was the last position
					if (k < entries) begin
						swim(k);
						sink(k);
					end
					heap_pos[s] = CAP;
					slot_key[s] = '0;
				end else if (c.command == ibhpq_pkg::CMD_CHANGE) begin
					slot_key[s] = c.key_value;
					swim(heap_pos[s]);
					sink(heap_pos[s]);
				end else if (c.command == ibhpq_pkg::CMD_DECREASE) begin
					if (key_worse(c.key_value, slot_key[s])) begin
						r.status = ibhpq_pkg::ST_NOCHANGE;
					end else begin
						slot_key[s] = c.key_value;
						swim(heap_pos[s]);
					end
				end else begin
					if (key_worse(slot_key[s], c.key_value)) begin
						r.status = ibhpq_pkg::ST_NOCHANGE;
					end else begin
						slot_key[s] = c.key_value;
						sink(heap_pos[s]);
					end
				end
			end
			default: r.status = ibhpq_pkg::ST_NOCHANGE;
		endcase
		r.entry_count = CW'(entries);
		if (entries > 0) begin
			r.top_valid = 1'b1;
			r.top_index = heap_slot[0];
			r.top_key = slot_key[heap_slot[0]];
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [KW-1:0] exp_v,
		logic [KW-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ibhpq_pkg::rsp_t e;
		if (!arst_n) begin
			largest_on_top <= 1'b0;
			entries = 0;
			errors = 0;
			pending = 0;
			expected_rsp.delete();
			for (int i = 0; i < CAP; i++) begin
				heap_slot[i] = '0;
				heap_pos[i] = CAP;
				slot_key[i] = '0;
			end
		end else begin
			// the mode register must only change while the queue is idle; the queue does not enforce it
			if (cfg_valid && cfg_ready)
				largest_on_top <= cfg_data;
			if (cmd_valid && cmd_ready)
				expected_rsp.push_back(apply_command(cmd));
			// compare each response beat with the oldest expectation
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$error("response beat with nothing expected");
					errors++;
				end else begin
					e = expected_rsp.pop_front();
					check_field("status", KW'(e.status), KW'(rsp.status));
					check_field("removed_index", KW'(e.removed_index),
						KW'(rsp.removed_index));
					check_field("removed_key", e.removed_key, rsp.removed_key);
					check_field("entry_count", KW'(e.entry_count), KW'(rsp.entry_count));
					check_field("top_valid", KW'(e.top_valid), KW'(rsp.top_valid));
					check_field("top_index", KW'(e.top_index), KW'(rsp.top_index));
					check_field("top_key", e.top_key, rsp.top_key);
				end
			end
			pending = expected_rsp.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 40;
	localparam int IW = ibhpq_pkg::IDX_W;
	localparam int KW = ibhpq_pkg::KEY_W;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	ibhpq_pkg::cmd_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	ibhpq_pkg::rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	int   errors;
	int   pending;
	int   cycles = 0;
	bit   calm;

	indexed_binary_heap_priority_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	heap_result_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("indexed_binary_heap_priority_queue regression: fail");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	// stall the response side between beats
	initial begin
		int w;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		rsp_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				w = draw_gap();
				if (w > 0) begin
					rsp_ready <= 1'b0;
					repeat (w) @(posedge clk);
					rsp_ready <= 1'b1;
				end
			end
		end
	end

	task automatic send(logic [2:0] op, logic [IW-1:0] s, logic [KW-1:0] k);
		int w;
		w = draw_gap();
		if (w > 0) begin
			cmd_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		cmd <= '{command: op, slot_index: s, key_value: k};
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
	endtask

	// drop valid and wait out every outstanding response
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_mode(logic m);
		cfg_data <= m;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [KW-1:0] draw_key();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 7);
			1: return '1 - $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int fill_pct;
		int r;
		logic [2:0] op;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		calm = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, key extremes, every status
		write_mode(1'b0);
		send(ibhpq_pkg::CMD_DEL_TOP, 6'd0, '0);
		send(ibhpq_pkg::CMD_INSERT, 6'd5, 32'hFFFF_FFFF);
		send(ibhpq_pkg::CMD_INSERT, 6'd63, 32'h0);
		send(ibhpq_pkg::CMD_INSERT, 6'd0, 32'h8000_0000);
		send(ibhpq_pkg::CMD_INSERT, 6'd5, 32'h1);
		send(ibhpq_pkg::CMD_DECREASE, 6'd5, 32'h7);
		send(ibhpq_pkg::CMD_DECREASE, 6'd5, 32'hFFFF_FFFF);
		send(ibhpq_pkg::CMD_INCREASE, 6'd63, 32'h0);
		send(ibhpq_pkg::CMD_INCREASE, 6'd63, 32'h3);
		send(ibhpq_pkg::CMD_INCREASE, 6'd0, 32'h1);
		send(ibhpq_pkg::CMD_CHANGE, 6'd0, 32'h2);
		send(ibhpq_pkg::CMD_REMOVE, 6'd42, 32'h0);
		send(ibhpq_pkg::CMD_CHANGE, 6'd42, 32'h9);
		send(ibhpq_pkg::CMD_DECREASE, 6'd42, 32'h9);
		send(ibhpq_pkg::CMD_INCREASE, 6'd42, 32'h9);
		send(3'd6, 6'd21, 32'h5555_5555);
		send(3'd7, 6'd42, 32'hAAAA_AAAA);
		send(ibhpq_pkg::CMD_REMOVE, 6'd5, 32'h0);
		send(ibhpq_pkg::CMD_REMOVE, 6'd63, 32'h0);
		send(ibhpq_pkg::CMD_DEL_TOP, 6'd0, '0);
		send(ibhpq_pkg::CMD_DEL_TOP, 6'd0, '0);
		send(ibhpq_pkg::CMD_INSERT, 6'd1, 32'h10);
		send(ibhpq_pkg::CMD_INSERT, 6'd2, 32'h20);
		drain();
		// switch mode with entries left in place
		write_mode(1'b1);
		send(ibhpq_pkg::CMD_INSERT, 6'd3, 32'h30);
		send(ibhpq_pkg::CMD_DEL_TOP, 6'd0, '0);

		// random phases; one phase mostly inserts and fills the queue toward capacity
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_mode(ph[0]);
			calm = (ph == 2);
			for (int i = 0; i < 125; i++) begin
				fill_pct = (ph == 3) ? 85 : (i < 70 ? 55 : 20);
				r = $urandom_range(0, 99);
				if (r < fill_pct)
					op = ibhpq_pkg::CMD_INSERT;
				else if ($urandom_range(0, 40) == 0)
					op = 3'($urandom_range(6, 7));
				else
					op = 3'($urandom_range(1, 5));
				send(op, 6'($urandom_range(0, 63)), draw_key());
			end
		end

		drain();
		if (errors == 0)
			$display("indexed_binary_heap_priority_queue regression: pass");
		else
			$display("indexed_binary_heap_priority_queue regression: fail");
		$finish;
	end

endmodule
